// File: rtl/q12alu_pkg.sv
// Shared types and constants for the Q12.4 fixed-point arithmetic unit.
package q12alu_pkg;

	localparam int WORD_BITS     = 16;
	localparam int FRACTION_BITS = 4;

	// Divider widths: |a| << (F-1) needs W+F-1 bits, |b>>>1| needs W-1 bits
	localparam int NUM_BITS = WORD_BITS + FRACTION_BITS - 1;
	localparam int DEN_BITS = WORD_BITS - 1;

	typedef enum logic [2:0] {
		OP_ABS   = 3'd0,
		OP_MUL   = 3'd1,
		OP_DIV   = 3'd2,
		OP_FLOOR = 3'd3,
		OP_CEIL  = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]                  operation;
		logic signed [WORD_BITS-1:0] operand_a;
		logic signed [WORD_BITS-1:0] operand_b;
	} alu_cmd_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] result;
		logic                        divide_fault;
	} alu_rsp_t;

endpackage

// File: rtl/q12_4_fixed_point_alu_top.sv
// Q12.4 fixed-point arithmetic unit: abs, multiply, divide, floor, ceil.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one transaction per cycle
//   while cmd_ready is high, each an operation code and two signed Q12.4 operands.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one transaction per command,
//   in order: the wrapped 16-bit result and the divide fault flag.
//   A transaction passes from the accepting edge to rsp_valid through one input
//   stage, one restoring-divider stage per quotient bit (19), and the output
//   register. All operations take the same path.
//   Throughput is one transaction per cycle while the output is not stalled;
//   every stage, including the divider's, holds one transaction.
//   Reset clears all valid bits; nothing is in flight afterwards.
//   When rsp_ready is low the output register holds its transaction; the
//   pipeline keeps moving until its last stage is occupied, then stalls as a
//   whole and cmd_ready drops. No transaction is lost or duplicated.
//   Unused operation codes return zero.
module q12_4_fixed_point_alu_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  q12alu_pkg::alu_cmd_t cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output q12alu_pkg::alu_rsp_t rsp
);
	import q12alu_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int NB = NUM_BITS;
	localparam int DB = DEN_BITS;

	localparam logic [W-1:0] FRAC_MASK = {{(W-F){1'b0}}, {F{1'b1}}};
	localparam logic [W-1:0] UNIT      = W'(1) << F;

	logic adv;
	logic out_load;

	// ---------------- input decode ----------------
	logic signed [W-1:0]   a_c;
	logic signed [W-1:0]   b_c;
	logic [W-1:0]          abs_a_c;
	logic [W-1:0]          floor_c;
	logic [DB-1:0]         d_c;
	logic [DB-1:0]         dmag_c;
	logic                  d_zero_c;
	logic                  ab_zero_c;
	logic [W-1:0]          res_c;
	logic                  is_mul_c;
	logic                  run_c;
	logic                  fault_c;
	logic signed [2*W-1:0] prod_c;

	always_comb begin
		a_c       = cmd.operand_a;
		b_c       = cmd.operand_b;
		abs_a_c   = a_c[W-1] ? (W'(0) - a_c) : a_c;
		floor_c   = a_c & ~FRAC_MASK;
		d_c       = b_c[W-1:1];
		dmag_c    = d_c[DB-1] ? (DB'(0) - d_c) : d_c;
		d_zero_c  = (d_c == '0);
		ab_zero_c = (a_c == '0) || (b_c == '0);
		prod_c    = a_c * b_c;
		res_c     = '0;
		is_mul_c  = 1'b0;
		run_c     = 1'b0;
		fault_c   = 1'b0;
		case (op_t'(cmd.operation))
			OP_ABS: begin
				res_c = abs_a_c;
			end
			OP_MUL: begin
				is_mul_c = 1'b1;
			end
			OP_DIV: begin
				res_c   = a_c;
				run_c   = !ab_zero_c && !d_zero_c;
				fault_c = !ab_zero_c && d_zero_c;
			end
			OP_FLOOR: begin
				res_c = floor_c;
			end
			OP_CEIL: begin
				res_c = ((a_c & FRAC_MASK) != '0) ? (floor_c + UNIT) : floor_c;
			end
			default: begin
				res_c = '0;
			end
		endcase
	end

	// ---------------- stage 1 ----------------
	logic            v_s1;
	logic [W-1:0]    res_s1;
	logic            is_mul_s1;
	logic            run_s1;
	logic            fault_s1;
	logic            neg_s1;
	logic [NB-1:0]   num_s1;
	logic [DB-1:0]   dmag_s1;
	logic [W+F-1:0]  prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s1    <= res_c;
			is_mul_s1 <= is_mul_c;
			run_s1    <= run_c;
			fault_s1  <= fault_c;
			neg_s1    <= a_c[W-1] ^ b_c[W-1];
			num_s1    <= NB'(abs_a_c) << (F - 1);
			dmag_s1   <= dmag_c;
			prod_s1   <= prod_c[W+F-1:0];
		end
	end

	// multiply rounding: half up on the dropped fraction, then wrap
	logic [W-1:0] mul_res_c;
	assign mul_res_c = prod_s1[W+F-1:F] + W'(prod_s1[F-1]);

	// ---------------- divider stages (one quotient bit each) ----------------
	logic [NB-1:0] v_s2;
	logic [DB-1:0] rem_s2   [NB];
	logic [NB-1:0] nq_s2    [NB];
	logic [DB-1:0] dmag_s2  [NB];
	logic [W-1:0]  res_s2   [NB];
	logic [NB-1:0] run_s2;
	logic [NB-1:0] fault_s2;
	logic [NB-1:0] neg_s2;

	logic [NB-1:0] vi_c;
	logic [DB-1:0] remi_c   [NB];
	logic [NB-1:0] nqi_c    [NB];
	logic [DB-1:0] dmagi_c  [NB];
	logic [W-1:0]  resi_c   [NB];
	logic [NB-1:0] runi_c;
	logic [NB-1:0] faulti_c;
	logic [NB-1:0] negi_c;
	logic [DB:0]   trial_c  [NB];
	logic [DB:0]   diff_c   [NB];
	logic [NB-1:0] ge_c;

	always_comb begin
		for (int k = 0; k < NB; k++) begin
			if (k == 0) begin
				vi_c[k]     = v_s1;
				remi_c[k]   = '0;
				nqi_c[k]    = num_s1;
				dmagi_c[k]  = dmag_s1;
				resi_c[k]   = is_mul_s1 ? mul_res_c : res_s1;
				runi_c[k]   = run_s1;
				faulti_c[k] = fault_s1;
				negi_c[k]   = neg_s1;
			end else begin
				vi_c[k]     = v_s2[k-1];
				remi_c[k]   = rem_s2[k-1];
				nqi_c[k]    = nq_s2[k-1];
				dmagi_c[k]  = dmag_s2[k-1];
				resi_c[k]   = res_s2[k-1];
				runi_c[k]   = run_s2[k-1];
				faulti_c[k] = fault_s2[k-1];
				negi_c[k]   = neg_s2[k-1];
			end
			trial_c[k] = {remi_c[k], nqi_c[k][NB-1]};
			diff_c[k]  = trial_c[k] - {1'b0, dmagi_c[k]};
			ge_c[k]    = (trial_c[k] >= {1'b0, dmagi_c[k]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= '0;
		end else if (adv) begin
			v_s2 <= vi_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NB; k++) begin
				rem_s2[k]   <= ge_c[k] ? diff_c[k][DB-1:0] : trial_c[k][DB-1:0];
				nq_s2[k]    <= {nqi_c[k][NB-2:0], ge_c[k]};
				dmag_s2[k]  <= dmagi_c[k];
				res_s2[k]   <= resi_c[k];
			end
			run_s2   <= runi_c;
			fault_s2 <= faulti_c;
			neg_s2   <= negi_c;
		end
	end

	// ---------------- output register ----------------
	logic          rsp_valid_q;
	alu_rsp_t      rsp_q;
	logic [NB-1:0] quo_c;
	logic [NB-1:0] quo_s_c;
	alu_rsp_t      rsp_c;

	always_comb begin
		quo_c              = nq_s2[NB-1];
		quo_s_c            = neg_s2[NB-1] ? (NB'(0) - quo_c) : quo_c;
		rsp_c.result       = run_s2[NB-1] ? quo_s_c[W-1:0] : res_s2[NB-1];
		rsp_c.divide_fault = fault_s2[NB-1];
	end

	assign out_load  = !rsp_valid_q || rsp_ready;
	assign adv       = out_load || !v_s2[NB-1];
	assign cmd_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= v_s2[NB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= rsp_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> v_s1)
		else $error("accepted transaction did not reach stage 1");

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> (rsp_valid && !rsp_ready && v_s2[NB-1]))
		else $error("pipeline stalled without a blocked output");

	a_last_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2[NB-1] && !adv) |=> (v_s2[NB-1] && $stable(nq_s2[NB-1])))
		else $error("last divider stage changed while stalled");

	a_fault_excludes_run: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !(fault_s1 && run_s1))
		else $error("divide fault and division both flagged");

	a_div_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s2[0]) |=> v_s2[1])
		else $error("divider stage dropped a transaction");
`endif

endmodule

// File: tb/q12_alu_checker.sv
// Response checker for the Q12.4 arithmetic unit: predicts each result and compares in order.
`timescale 1ns / 100ps

module q12_alu_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  logic                 cmd_ready,
	input  q12alu_pkg::alu_cmd_t cmd,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  q12alu_pkg::alu_rsp_t rsp,
	output int                   mismatches,
	output int                   outstanding,
	output int                   faults_seen
);
	import q12alu_pkg::*;

	typedef struct {
		alu_cmd_t cmd;
		alu_rsp_t rsp;
	} pending_op_t;

	pending_op_t expected_rsp_q[$];
	int          mismatch_total = 0;
	int          fault_total    = 0;

	// Bit-exact model of one Q12.4 operation
	function automatic alu_rsp_t q12_compute(alu_cmd_t c);
		alu_rsp_t          r;
		logic signed [31:0] prod;
		logic [31:0]        rounded;
		int                 num;
		int                 den;
		r.result       = '0;
		r.divide_fault = 1'b0;
		case (c.operation)
			OP_ABS: begin
				// negating the most negative value wraps back to itself
				r.result = c.operand_a[WORD_BITS-1] ? -c.operand_a : c.operand_a;
			end
			OP_MUL: begin
				if (c.operand_a != 0 && c.operand_b != 0) begin
					prod    = c.operand_a * c.operand_b;
					rounded = prod;
					// round half up on the dropped fraction nibble
					if (rounded[FRACTION_BITS-1:0] >= (1 << (FRACTION_BITS - 1)))
						rounded = {rounded[31:FRACTION_BITS], {FRACTION_BITS{1'b0}}}
							+ (32'd1 << FRACTION_BITS);
					r.result = rounded[WORD_BITS+FRACTION_BITS-1:FRACTION_BITS];
				end
			end
			OP_DIV: begin
				if (c.operand_a == 0 || c.operand_b == 0) begin
					r.result = c.operand_a;
				end else begin
					den = c.operand_b >>> 1;
					if (den == 0) begin
						r.result       = c.operand_a;
						r.divide_fault = 1'b1;
					end else begin
						num      = c.operand_a * (1 << (FRACTION_BITS - 1));
						r.result = num / den;
					end
				end
			end
			OP_FLOOR: begin
				r.result = {c.operand_a[WORD_BITS-1:FRACTION_BITS], {FRACTION_BITS{1'b0}}};
			end
			OP_CEIL: begin
				r.result = {c.operand_a[WORD_BITS-1:FRACTION_BITS], {FRACTION_BITS{1'b0}}};
				if (c.operand_a[FRACTION_BITS-1:0] != 0)
					r.result = r.result + (16'sd1 <<< FRACTION_BITS);
			end
			default: begin
				r.result = '0;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatch_total++;
	endtask

	always @(posedge clk) begin
		pending_op_t p;
		pending_op_t head;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				p.cmd = cmd;
				p.rsp = q12_compute(cmd);
				expected_rsp_q.push_back(p);
			end
			if (rsp_valid && rsp_ready) begin
				if (rsp.divide_fault)
					fault_total++;
				if (expected_rsp_q.size() == 0) begin
					report_mismatch($sformatf("unexpected transaction result=%h fault=%b",
						rsp.result, rsp.divide_fault));
				end else begin
					head = expected_rsp_q.pop_front();
					if (rsp.result !== head.rsp.result)
						report_mismatch($sformatf("op=%0d a=%h b=%h: result %h, expected %h",
							head.cmd.operation, head.cmd.operand_a, head.cmd.operand_b,
							rsp.result, head.rsp.result));
					if (rsp.divide_fault !== head.rsp.divide_fault)
						report_mismatch($sformatf("op=%0d a=%h b=%h: fault %b, expected %b",
							head.cmd.operation, head.cmd.operand_a, head.cmd.operand_b,
							rsp.divide_fault, head.rsp.divide_fault));
				end
			end
		end
		mismatches  <= mismatch_total;
		outstanding <= expected_rsp_q.size();
		faults_seen <= fault_total;
	end

endmodule

// File: tb/q12_4_fixed_point_alu_top_test.sv
// Stimulus and verdict for the Q12.4 arithmetic unit: directed corners, then random traffic.
`timescale 1ns / 100ps

module q12_4_fixed_point_alu_top_test;
	import q12alu_pkg::*;

	localparam logic [2:0] FIRST_UNUSED_OP = 3'd5;
	localparam logic [2:0] LAST_OP_CODE    = 3'd7;
	localparam int         RANDOM_ITEMS    = 900;
	localparam int         QUIET_ITEMS     = 150;
	localparam int         HOLD_OFF_AT     = 300;
	localparam int         HOLD_OFF_CYCLES = 100;
	localparam int         DRAIN_CYCLES    = 2 * (WORD_BITS + FRACTION_BITS);
	localparam int         CYCLE_LIMIT     = 100000;

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_ready;
	alu_cmd_t cmd       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	alu_rsp_t rsp;

	int mismatches;
	int outstanding;
	int faults_seen;
	int cycle_count   = 0;
	int op_hits[8];
	bit quiet         = 1'b0;
	bit hold_off_req  = 1'b0;
	bit hold_off_done = 1'b0;

	q12_4_fixed_point_alu_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	q12_alu_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.faults_seen (faults_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, outstanding);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Response side: random back-pressure bursts plus one long hold-off
	initial begin
		int idle_left;
		int hold_left;
		idle_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
				if (hold_left == 0)
					hold_off_done = 1'b1;
			end else if (quiet) begin
				rsp_ready <= 1'b1;
			end else if (idle_left > 0) begin
				rsp_ready <= 1'b0;
				idle_left--;
			end else if ($urandom_range(0, 4) == 0) begin
				rsp_ready <= 1'b0;
				idle_left = $urandom_range(1, 6) - 1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Offer one transaction, wait for the edge that accepts it, and sometimes idle after
	task automatic send_op(logic [2:0] op, logic [15:0] a, logic [15:0] b);
		alu_cmd_t c;
		c.operation = op;
		c.operand_a = a;
		c.operand_b = b;
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		op_hits[op]++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_operand();
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: v = 16'h8000;
					1: v = 16'h7FFF;
					2: v = 16'h0000;
					3: v = 16'hFFFF;
					default: v = 16'h0001;
				endcase
			end
			1, 2: v = 16'($urandom_range(0, 128)) - 16'd64;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [15:0] pick_divisor();
		logic [15:0] v;
		case ($urandom_range(0, 14))
			0: v = 16'h0000;
			1: v = 16'h0001;
			2: v = 16'hFFFF;
			3: v = 16'h0002;
			4: v = 16'hFFFE;
			default: v = pick_operand();
		endcase
		return v;
	endfunction

	initial begin
		logic [2:0] op;
		int         pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// absolute value, including the wrap of the most negative value
		send_op(OP_ABS, 16'h8000, 16'h1234);
		send_op(OP_ABS, 16'h7FFF, 16'h0000);
		send_op(OP_ABS, 16'hFFFF, 16'hFFFF);
		send_op(OP_ABS, 16'h0000, 16'h8000);
		// multiply: zero operands, rounding edges, overflow wrap
		send_op(OP_MUL, 16'h0000, 16'h7FFF);
		send_op(OP_MUL, 16'h8000, 16'h0000);
		send_op(OP_MUL, 16'h0001, 16'h0008);
		send_op(OP_MUL, 16'h0001, 16'h0007);
		send_op(OP_MUL, 16'hFFFF, 16'h0008);
		send_op(OP_MUL, 16'h7FFF, 16'h7FFF);
		send_op(OP_MUL, 16'h8000, 16'h8000);
		send_op(OP_MUL, 16'h8000, 16'h7FFF);
		// divide: zero divisor, zero dividend, divisor of one, wraps
		send_op(OP_DIV, 16'h1234, 16'h0000);
		send_op(OP_DIV, 16'h0000, 16'h0001);
		send_op(OP_DIV, 16'hFFFB, 16'h0001);
		send_op(OP_DIV, 16'h8000, 16'hFFFF);
		send_op(OP_DIV, 16'h8000, 16'h0002);
		send_op(OP_DIV, 16'h7FFF, 16'h8000);
		// floor and ceil, including the ceil wrap at the top
		send_op(OP_FLOOR, 16'h7FFF, 16'h0000);
		send_op(OP_FLOOR, 16'h8001, 16'hFFFF);
		send_op(OP_CEIL, 16'h7FF1, 16'h0000);
		send_op(OP_CEIL, 16'h7FF0, 16'h0000);
		send_op(OP_CEIL, 16'hFFFF, 16'h0000);
		// unused codes
		send_op(FIRST_UNUSED_OP, 16'h7FFF, 16'h8000);
		send_op(FIRST_UNUSED_OP + 3'd1, 16'hFFFF, 16'hFFFF);
		send_op(LAST_OP_CODE, 16'h8000, 16'h7FFF);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == HOLD_OFF_AT)
				hold_off_req = 1'b1;
			if (i == RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 6)
				op = 3'($urandom_range(FIRST_UNUSED_OP, LAST_OP_CODE));
			else
				op = 3'($urandom_range(OP_ABS, OP_CEIL));
			if (op == OP_DIV)
				send_op(op, pick_operand(), pick_divisor());
			else
				send_op(op, pick_operand(), pick_operand());
		end
		cmd_valid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d transactions: abs %0d, mul %0d, div %0d, floor %0d, ceil %0d, unused %0d",
			op_hits.sum(), op_hits[OP_ABS], op_hits[OP_MUL], op_hits[OP_DIV],
			op_hits[OP_FLOOR], op_hits[OP_CEIL],
			op_hits[FIRST_UNUSED_OP] + op_hits[FIRST_UNUSED_OP + 3'd1]
				+ op_hits[LAST_OP_CODE]);
		$display("Divide faults seen %0d, long response hold-off %s, mismatches %0d",
			faults_seen, hold_off_done ? "done" : "missed", mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: q12_4_fixed_point_alu_top.f
rtl/q12alu_pkg.sv
rtl/q12_4_fixed_point_alu_top.sv
tb/q12_alu_checker.sv
tb/q12_4_fixed_point_alu_top_test.sv
